### design/mvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_pkg
// shared types and constants of the 4x4 matrix vector transform
// ----------------------------------------------------------------------------
package mvt_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int N             = 4;
	localparam int WORD_W        = 32;
	localparam int PROD_W        = 2 * WORD_W;
	localparam int SUM_W         = PROD_W + 2;

	// queue depth is a power of two so the pointers wrap on their own
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = 2;
	localparam int QCNT_W        = 3;

	localparam logic OP_LOAD      = 1'b0;
	localparam logic OP_TRANSFORM = 1'b1;

	typedef struct packed {
		logic [N-1:0][WORD_W-1:0] value;
		logic                     ovf;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} qport_t;

endpackage

### design/mvt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_front
// takes requests, keeps the matrix, forms products and saturated row sums
// ----------------------------------------------------------------------------
module mvt_front #(
	parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [127:0]                s_axis_tdata,
	input  logic [2:0]                  s_axis_tuser,
	input  logic [mvt_pkg::QCNT_W-1:0]  q_count,
	output mvt_pkg::qport_t             q_wr
);

	localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
	localparam logic signed [mvt_pkg::SUM_W-1:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [mvt_pkg::SUM_W-1:0] SAT_LO = -66'sd2147483648;

	logic                            fire;
	logic                            opcode;
	logic [1:0]                      row_index;
	logic signed [31:0]              elem [4];
	logic [mvt_pkg::QCNT_W:0]        in_flight;

	logic signed [31:0]              mat_q [4][4];
	logic signed [63:0]              prod_s1 [4][4];
	logic                            v_s1;
	logic signed [63:0]              sh [4][4];
	logic signed [mvt_pkg::SUM_W-1:0] sum [4];
	mvt_pkg::result_t                res_comb;
	mvt_pkg::result_t                res_s2;
	logic                            v_s2;

	assign opcode    = s_axis_tuser[0];
	assign row_index = s_axis_tuser[2:1];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			elem[c] = s_axis_tdata[32*c +: 32];
		end
	end

	// credit: pipeline plus queue never hold more than the queue depth
	assign in_flight = (mvt_pkg::QCNT_W+1)'(q_count) + (mvt_pkg::QCNT_W+1)'(v_s1)
	                 + (mvt_pkg::QCNT_W+1)'(v_s2);
	assign s_axis_tready = in_flight < (mvt_pkg::QCNT_W+1)'(mvt_pkg::QUEUE_DEPTH);
	assign fire = s_axis_tvalid && s_axis_tready;

	// matrix store, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					mat_q[r][c] <= (r == c) ? ONE : 32'd0;
				end
			end
		end else if (fire && opcode == mvt_pkg::OP_LOAD) begin
			for (int c = 0; c < 4; c++) begin
				mat_q[row_index][c] <= elem[c];
			end
		end
	end

	// stage 1: sixteen products
	always_ff @(posedge clk) begin
		if (fire && opcode == mvt_pkg::OP_TRANSFORM) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= 64'(mat_q[r][c]) * 64'(elem[c]);
				end
			end
		end
	end

	// stage 2: shift, exact sum, saturate
	always_comb begin
		res_comb.ovf = 1'b0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				sh[r][c] = prod_s1[r][c] >>> FRAC_BITS;
			end
			sum[r] = {{2{sh[r][0][63]}}, sh[r][0]} + {{2{sh[r][1][63]}}, sh[r][1]}
			       + {{2{sh[r][2][63]}}, sh[r][2]} + {{2{sh[r][3][63]}}, sh[r][3]};
			if (sum[r] > SAT_HI) begin
				res_comb.value[r] = 32'h7FFF_FFFF;
				res_comb.ovf      = 1'b1;
			end else if (sum[r] < SAT_LO) begin
				res_comb.value[r] = 32'h8000_0000;
				res_comb.ovf      = 1'b1;
			end else begin
				res_comb.value[r] = sum[r][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			res_s2 <= res_comb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= fire && opcode == mvt_pkg::OP_TRANSFORM;
			v_s2 <= v_s1;
		end
	end

	assign q_wr.valid = v_s2;
	assign q_wr.data  = res_s2;

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && opcode == mvt_pkg::OP_LOAD |=> !v_s1)
		else $error("load request entered the product stage");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight <= (mvt_pkg::QCNT_W+1)'(mvt_pkg::QUEUE_DEPTH))
		else $error("more results in flight than queue entries");

endmodule

### design/mvt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_queue
// short result queue between the arithmetic front and the output stage
// ----------------------------------------------------------------------------
module mvt_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mvt_pkg::qport_t             wr,
	input  logic                        pop,
	output mvt_pkg::qport_t             head,
	output logic [mvt_pkg::QCNT_W-1:0]  count
);

	mvt_pkg::result_t               mem [mvt_pkg::QUEUE_DEPTH];
	logic [mvt_pkg::QPTR_W-1:0]     wptr_q;
	logic [mvt_pkg::QPTR_W-1:0]     rptr_q;
	logic [mvt_pkg::QCNT_W-1:0]     count_q;

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			mem[wptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr.valid) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + mvt_pkg::QCNT_W'(wr.valid) - mvt_pkg::QCNT_W'(pop);
		end
	end

	assign head.valid = count_q != '0;
	assign head.data  = mem[rptr_q];
	assign count      = count_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid |-> count_q < mvt_pkg::QCNT_W'(mvt_pkg::QUEUE_DEPTH))
		else $error("push into a full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from an empty queue");

endmodule

### design/mvt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_back
// output register that drains the queue onto the result stream
// ----------------------------------------------------------------------------
module mvt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mvt_pkg::qport_t     head,
	output logic                pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [127:0]        m_axis_tdata,
	output logic [0:0]          m_axis_tuser
);

	mvt_pkg::result_t out_q;
	logic             out_valid_q;

	assign pop = head.valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.value;
	assign m_axis_tuser  = out_q.ovf;

	a_refill_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && m_axis_tready && head.valid |=> out_valid_q)
		else $error("output register emptied while the queue held a result");

endmodule

### design/matrix_vector_transform_4x4.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4
// 4x4 q16.16 matrix store with saturated matrix times vector transform
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata elem_0..3, tuser opcode,row_index
//  m_axis    out  m_axis_tvalid/tready    tdata out_0..3, tuser overflow
//
//  one request per cycle while s_axis_tready is high, loads and transforms alike
//  a transform result goes through the product stage, the sum stage, the queue
//  and the output register before it shows on m_axis
//  reset sets the matrix to identity and empties the queue
//  a stalled m_axis fills the four-entry queue; tready drops at four in flight
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4 #(
	parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,  // elem_0, elem_1, elem_2, elem_3
	input  logic [2:0]    s_axis_tuser,  // opcode, row_index
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [127:0]  m_axis_tdata,  // out_0, out_1, out_2, out_3
	output logic [0:0]    m_axis_tuser   // overflow
);

	mvt_pkg::qport_t                q_wr;
	mvt_pkg::qport_t                q_head;
	logic                           q_pop;
	logic [mvt_pkg::QCNT_W-1:0]     q_count;

	mvt_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_count       (q_count),
		.q_wr          (q_wr)
	);

	mvt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.head   (q_head),
		.count  (q_count)
	);

	mvt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
